// File: rtl/core/swfrm_pkg.sv
// Shared widths, command codes and constants of the frame-rate meter.
package swfrm_pkg;

  localparam int TIME_W   = 32;
  localparam int WIN_W    = 16;
  localparam int CMD_W    = 2;
  localparam int RATE_W   = 26;
  localparam int FRAMES_W = 9;
  localparam int NUM_W    = 32;
  localparam int STEP_W   = $clog2(NUM_W);

  localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [WIN_W-1:0]  WINDOW_RESET = 16'd5000;
  // 1000 ms per second times 256 for Q8
  localparam logic [NUM_W-1:0]  RATE_SCALE   = 32'd256000;
  localparam logic [RATE_W-1:0] RATE_MAX     = '1;

endpackage

// File: rtl/core/swfrm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module swfrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/sliding_window_frame_rate_meter_core.sv
// Top level of the sliding-window frame-rate meter.
//
// Usage: a request is accepted when start is high and busy is low.
// in_command selects record (store in_time_ms in the timestamp ring),
// query (measure the rate at time in_time_ms) or clear (empty the ring);
// code 3 is ignored. For record, clear and ignored codes busy stays low.
// A query raises busy and walks back through the ring one entry per
// cycle (one RAM read per cycle, registered read data), then runs a
// 32-step restoring divider, one quotient bit per cycle; when fewer
// than two frames are kept or the span is zero, it skips the divider
// and reports a rate of zero. The result is shown on out_rate_q8 and
// out_frames_in_window for one cycle with out_valid high; the receiver
// cannot stall it, and busy falls in the same cycle. cfg_we writes
// window_ms from cfg_wdata; write it only while idle. Synchronous reset
// empties the ring, sets the window to 5000 ms and returns to idle; ring
// contents stay undefined until written.
module sliding_window_frame_rate_meter_core #(
  parameter int RING_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [swfrm_pkg::CMD_W-1:0]    in_command,
  input  logic [swfrm_pkg::TIME_W-1:0]   in_time_ms,
  output logic                           out_valid,
  output logic [swfrm_pkg::RATE_W-1:0]   out_rate_q8,
  output logic [swfrm_pkg::FRAMES_W-1:0] out_frames_in_window,
  input  logic                           cfg_we,
  input  logic [swfrm_pkg::WIN_W-1:0]    cfg_wdata
);

  import swfrm_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_WALK,
    ST_CALC,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [WIN_W-1:0]     window_r, window_nxt;
  logic [PTR_W-1:0]     wp_r, wp_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [PTR_W-1:0]     addr_r, addr_nxt;
  logic [CNT_W-1:0]     kept_r, kept_nxt;
  logic [TIME_W-1:0]    now_r, now_nxt;
  logic [TIME_W-1:0]    newest_r, newest_nxt;
  logic [TIME_W-1:0]    oldest_r, oldest_nxt;
  logic [TIME_W-1:0]    span_r, span_nxt;
  logic [NUM_W-1:0]     num_r, num_nxt;
  logic [TIME_W-1:0]    rem_r, rem_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [RATE_W-1:0]    rate_r, rate_nxt;
  logic [FRAMES_W-1:0]  frames_r, frames_nxt;

  logic                 ram_we;
  logic [TIME_W-1:0]    ram_rdata;
  logic                 accept;
  logic [TIME_W-1:0]    age;
  logic [TIME_W:0]      shifted;
  logic [TIME_W:0]      diff;

  swfrm_ram #(
    .WIDTH (TIME_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_time_ms),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign accept = start && (state_r == ST_IDLE);
  assign ram_we = accept && (in_command == CMD_RECORD);
  assign age    = now_r - ram_rdata;
  assign shifted = {rem_r, num_r[NUM_W-1]};
  assign diff    = shifted - {1'b0, span_r};

  always_comb begin
    state_nxt     = state_r;
    window_nxt    = window_r;
    wp_nxt        = wp_r;
    count_nxt     = count_r;
    addr_nxt      = addr_r;
    kept_nxt      = kept_r;
    now_nxt       = now_r;
    newest_nxt    = newest_r;
    oldest_nxt    = oldest_r;
    span_nxt      = span_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    out_valid_nxt = 1'b0;
    rate_nxt      = rate_r;
    frames_nxt    = frames_r;

    if (cfg_we) begin
      window_nxt = cfg_wdata;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_RECORD: begin
              wp_nxt = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
              if (count_r != CNT_FULL) begin
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_QUERY: begin
              now_nxt   = in_time_ms;
              kept_nxt  = '0;
              addr_nxt  = (wp_r == '0) ? PTR_LAST : wp_r - 1'b1;
              state_nxt = ST_PRIME;
            end
            CMD_CLEAR: begin
              wp_nxt    = '0;
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PRIME: begin
        addr_nxt  = (addr_r == '0) ? PTR_LAST : addr_r - 1'b1;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if ((kept_r == count_r) || (age > {{(TIME_W-WIN_W){1'b0}}, window_r})) begin
          state_nxt = ST_CALC;
        end else begin
          kept_nxt   = kept_r + 1'b1;
          oldest_nxt = ram_rdata;
          if (kept_r == '0) begin
            newest_nxt = ram_rdata;
          end
          addr_nxt = (addr_r == '0) ? PTR_LAST : addr_r - 1'b1;
        end
      end
      ST_CALC: begin
        span_nxt = newest_r - oldest_r;
        rem_nxt  = '0;
        step_nxt = '0;
        if ((kept_r < CNT_W'(2)) || (newest_r == oldest_r)) begin
          num_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          num_nxt   = NUM_W'(NUM_W'(kept_r - 1'b1) * RATE_SCALE);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!diff[TIME_W]) begin
          rem_nxt = diff[TIME_W-1:0];
          num_nxt = {num_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = shifted[TIME_W-1:0];
          num_nxt = {num_r[NUM_W-2:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(NUM_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        rate_nxt      = (num_r > NUM_W'(RATE_MAX)) ? RATE_MAX : num_r[RATE_W-1:0];
        frames_nxt    = FRAMES_W'(kept_r);
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_r    <= WINDOW_RESET;
      wp_r        <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      window_r    <= window_nxt;
      wp_r        <= wp_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r   <= addr_nxt;
    kept_r   <= kept_nxt;
    now_r    <= now_nxt;
    newest_r <= newest_nxt;
    oldest_r <= oldest_nxt;
    span_r   <= span_nxt;
    num_r    <= num_nxt;
    rem_r    <= rem_nxt;
    step_r   <= step_nxt;
    rate_r   <= rate_nxt;
    frames_r <= frames_nxt;
  end

  assign busy                 = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_rate_q8          = rate_r;
  assign out_frames_in_window = frames_r;

endmodule
